// ----- hdl/kmeans_lloyd_cluster_core_defines.svh -----
// Assertion macros shared by the k-means cluster core.
// The files that use them need signals clk and rst_n in scope.
`ifndef KMEANS_LLOYD_CLUSTER_CORE_DEFINES_SVH
`define KMEANS_LLOYD_CLUSTER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KMLC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kmlc check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define KMLC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kmlc check failed one cycle later");

`endif

// ----- hdl/kmlc_pkg.sv -----
// Types, sizes and codes shared by the k-means cluster core.
// No dependencies.
package kmlc_pkg;

  localparam int NUM_CLUSTERS = 8;
  localparam int NUM_DIMS     = 4;
  localparam int COORD_W      = 16;
  localparam int NUM_POINTS   = 1024;
  localparam int PT_AW        = $clog2(NUM_POINTS);
  localparam int CL_W         = $clog2(NUM_CLUSTERS);
  localparam int DIM_W        = $clog2(NUM_DIMS);
  localparam int CNT_W        = PT_AW + 1;
  localparam int SUM_W        = COORD_W + PT_AW;
  localparam int SQ_W         = 2 * (COORD_W + 1);
  localparam int DIST_W       = SQ_W + $clog2(NUM_DIMS);
  localparam int PT_W         = NUM_DIMS * COORD_W;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_SEED  = 2'd1,
    ACT_RUN   = 2'd2,
    ACT_LABEL = 2'd3
  } action_t;

  localparam logic [2:0] REG_CLUSTER_COUNT = 3'd0;
  localparam logic [2:0] REG_PASS_LIMIT    = 3'd1;
  localparam logic [2:0] REG_POINT_COUNT   = 3'd2;
  localparam logic [2:0] REG_DIMS_IN_USE   = 3'd3;
  localparam logic [2:0] REG_MOVE_TOL      = 3'd4;

  typedef logic [NUM_DIMS-1:0][COORD_W-1:0] point_t;
  typedef logic [NUM_DIMS-1:0][SUM_W-1:0]   sums_t;

  typedef struct packed {
    logic               clear;
    logic               acc;
    logic               seed;
    logic               wr;
    logic [DIM_W-1:0]   wr_dim;
    logic [COORD_W-1:0] wr_val;
    logic [2:0]         dims;
  } lane_ctl_t;

endpackage

// ----- hdl/kmlc_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module kmlc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/kmlc_div.sv -----
// Shared restoring divider: signed sum over unsigned count, truncated toward zero.
// Depends on kmlc_pkg.
module kmlc_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [kmlc_pkg::SUM_W-1:0] dividend,
  input  logic [kmlc_pkg::CNT_W-1:0] divisor,
  output logic                       busy,
  output logic                       done,
  output logic [kmlc_pkg::SUM_W-1:0] quotient
);
  import kmlc_pkg::*;

  localparam int STEP_W = $clog2(SUM_W);

  logic              busy_r;
  logic              done_r;
  logic              neg_r;
  logic [STEP_W-1:0] step_r;
  logic [SUM_W-1:0]  q_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  dvs_r;
  logic [CNT_W:0]    trial;
  logic              fits;

  assign trial = {rem_r, q_r[SUM_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
        neg_r  <= dividend[SUM_W-1];
        q_r    <= dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
        rem_r  <= '0;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= fits ? CNT_W'(trial - {1'b0, dvs_r}) : CNT_W'(trial);
        q_r   <= {q_r[SUM_W-2:0], fits};
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(SUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = neg_r ? (~q_r + 1'b1) : q_r;

endmodule

// ----- hdl/kmlc_lane.sv -----
// One cluster lane: holds a centroid, computes the squared distance of the
// current point and accumulates member sums and count. Depends on kmlc_pkg.
module kmlc_lane (
  input  logic                        clk,
  input  kmlc_pkg::lane_ctl_t         ctl,
  input  kmlc_pkg::point_t            pt,
  output logic [kmlc_pkg::DIST_W-1:0] sq_dist,
  output kmlc_pkg::point_t            cent,
  output kmlc_pkg::sums_t             sums,
  output logic [kmlc_pkg::CNT_W-1:0]  count
);
  import kmlc_pkg::*;

  point_t             cent_r;
  sums_t              sum_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [SQ_W-1:0]    sq_r   [NUM_DIMS];
  logic [SQ_W-1:0]    sq_nxt [NUM_DIMS];
  logic [DIST_W-1:0]  dist_r;
  logic [DIST_W-1:0]  dist_nxt;

  // Squares are masked to zero for coordinates outside the distance.
  always_comb begin
    logic signed [COORD_W:0] df;
    logic signed [SQ_W-1:0]  pr;
    for (int j = 0; j < NUM_DIMS; j++) begin
      df = $signed({pt[j][COORD_W-1], pt[j]}) - $signed({cent_r[j][COORD_W-1], cent_r[j]});
      pr = df * df;
      sq_nxt[j] = (3'(j) < ctl.dims) ? SQ_W'(pr) : '0;
    end
  end

  always_comb begin
    dist_nxt = '0;
    for (int j = 0; j < NUM_DIMS; j++) begin
      dist_nxt = dist_nxt + DIST_W'(sq_r[j]);
    end
  end

  always_ff @(posedge clk) begin
    sq_r   <= sq_nxt;
    dist_r <= dist_nxt;
    if (ctl.clear) begin
      sum_r <= '0;
      cnt_r <= '0;
    end else if (ctl.acc) begin
      for (int j = 0; j < NUM_DIMS; j++) begin
        sum_r[j] <= sum_r[j] + {{(SUM_W-COORD_W){pt[j][COORD_W-1]}}, pt[j]};
      end
      cnt_r <= cnt_r + 1'b1;
    end
    if (ctl.seed) begin
      cent_r <= pt;
    end else if (ctl.wr) begin
      cent_r[ctl.wr_dim] <= ctl.wr_val;
    end
  end

  assign sq_dist = dist_r;
  assign cent    = cent_r;
  assign sums    = sum_r;
  assign count   = cnt_r;

endmodule

// ----- hdl/kmeans_lloyd_cluster_core.sv -----
// Top level of the Lloyd k-means cluster core: control sequencer, lanes,
// merging stage, shared divider and stores. Depends on kmlc_pkg, kmlc_ram,
// kmlc_lane, kmlc_div and kmeans_lloyd_cluster_core_defines.svh.

// This core clusters up to 1024 points of four signed 16-bit coordinates into
// up to eight clusters with Lloyd's algorithm. Points are loaded by beats with
// action 0, centroid slots are seeded from loaded points with action 1, a run
// is started with action 2 and a point's label is read with action 3. A load
// writes the point store as its beat is taken; a seed reads the point store,
// latches the point and writes it into its lane. A label read reads the label
// store and puts its answer in the output register once that register is free.
// A run, in each pass, takes each point through point memory read, latch, lane
// squares, lane sum and the merging compare across the lanes in use; then the
// shared bit-serial divider forms the mean of each coordinate of each non-empty
// cluster, one division at a time, and the pass ends with its bookkeeping. The
// number of passes is at most pass_limit and depends on the data; after them
// the run sends one record beat per cluster in use. Only one item is worked on
// at a time; in_tready is high only while the sequencer is idle, and a finished
// beat may wait in the output register while the next item is taken. The stores
// come up with no defined contents: points and centroids must be loaded and
// seeded before a run, and labels must come from a run before they are read.
`include "kmeans_lloyd_cluster_core_defines.svh"

module kmeans_lloyd_cluster_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // Fields from bit 0 up: point_index[9:0], cluster_index[12:10], coord_a[28:13],
  // coord_b[44:29], coord_c[60:45], coord_d[76:61], zero fill[79:77].
  input  logic [79:0] in_tdata,
  // Fields: action[1:0].
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // Fields from bit 0 up: cluster_id[2:0], center_a[18:3], center_b[34:19],
  // center_c[50:35], center_d[66:51], member_count[77:67], passes_done[85:78],
  // converged[86], zero fill[87].
  output logic [87:0] out_tdata,
  // Fields: kind[0].
  output logic [0:0]  out_tuser,
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import kmlc_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SEED_RD,
    ST_SEED_LAT,
    ST_SEED_WR,
    ST_LBL_RD,
    ST_LBL_OUT,
    ST_RUN,
    ST_PASS,
    ST_A_RD,
    ST_A_LAT,
    ST_A_SQ,
    ST_A_DS,
    ST_A_MG,
    ST_U_SEL,
    ST_U_WAIT,
    ST_P_END,
    ST_REP
  } state_t;

  // Configuration registers, kept at their register widths.
  logic [3:0]  k_cnt_r;
  logic [7:0]  pass_lim_r;
  logic [10:0] pt_cnt_r;
  logic [2:0]  dims_r;
  logic [15:0] tol_r;
  logic        cfg_we;

  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_cnt_r    <= 4'd2;
      pass_lim_r <= 8'd100;
      pt_cnt_r   <= 11'd1;
      dims_r     <= 3'd4;
      tol_r      <= 16'd0;
    end else if (cfg_we) begin
      unique case (cfg_paddr[4:2])
        REG_CLUSTER_COUNT: k_cnt_r    <= cfg_pwdata[3:0];
        REG_PASS_LIMIT:    pass_lim_r <= cfg_pwdata[7:0];
        REG_POINT_COUNT:   pt_cnt_r   <= cfg_pwdata[10:0];
        REG_DIMS_IN_USE:   dims_r     <= cfg_pwdata[2:0];
        REG_MOVE_TOL:      tol_r      <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[4:2])
      REG_CLUSTER_COUNT: cfg_prdata = {28'd0, k_cnt_r};
      REG_PASS_LIMIT:    cfg_prdata = {24'd0, pass_lim_r};
      REG_POINT_COUNT:   cfg_prdata = {21'd0, pt_cnt_r};
      REG_DIMS_IN_USE:   cfg_prdata = {29'd0, dims_r};
      REG_MOVE_TOL:      cfg_prdata = {16'd0, tol_r};
      default:           cfg_prdata = 32'd0;
    endcase
  end

  // Out-of-range register values are pulled into their legal ranges.
  logic [3:0]  k_use;
  logic [10:0] n_use;
  logic [2:0]  dims_use;

  assign k_use    = (k_cnt_r == 4'd0) ? 4'd1 :
                    (k_cnt_r > 4'(NUM_CLUSTERS)) ? 4'(NUM_CLUSTERS) : k_cnt_r;
  assign n_use    = (pt_cnt_r == 11'd0) ? 11'd1 :
                    (pt_cnt_r > 11'(NUM_POINTS)) ? 11'(NUM_POINTS) : pt_cnt_r;
  assign dims_use = (dims_r == 3'd0) ? 3'd1 :
                    (dims_r > 3'(NUM_DIMS)) ? 3'(NUM_DIMS) : dims_r;

  // Input beat fields.
  action_t          in_act;
  logic [PT_AW-1:0] in_pidx;
  logic [CL_W-1:0]  in_cidx;
  point_t           in_pt;
  logic             in_fire;

  assign in_act  = action_t'(in_tuser);
  assign in_pidx = in_tdata[9:0];
  assign in_cidx = in_tdata[12:10];
  assign in_pt   = in_tdata[76:13];

  state_t           state_r;
  logic [PT_AW-1:0] pidx_r;
  logic [CL_W-1:0]  cidx_r;
  logic [CNT_W-1:0] i_r;
  logic [3:0]       c_r;
  logic [DIM_W-1:0] j_r;
  logic [7:0]       pass_r;
  logic             moved_r;
  logic             conv_r;
  point_t           pt_r;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  // Point store and label store.
  logic             assign_phase;
  logic [PT_AW-1:0] pt_raddr;
  logic [PT_W-1:0]  pt_rdata;
  logic [CL_W-1:0]  lbl_rdata;
  logic [CL_W-1:0]  best;

  assign assign_phase = (state_r == ST_A_RD);
  assign pt_raddr     = assign_phase ? i_r[PT_AW-1:0] : pidx_r;

  kmlc_ram #(.WIDTH(PT_W), .DEPTH(NUM_POINTS)) u_point_ram (
    .clk   (clk),
    .we    (in_fire && (in_act == ACT_LOAD)),
    .waddr (in_pidx),
    .wdata (in_pt),
    .raddr (pt_raddr),
    .rdata (pt_rdata)
  );

  kmlc_ram #(.WIDTH(CL_W), .DEPTH(NUM_POINTS)) u_label_ram (
    .clk   (clk),
    .we    (state_r == ST_A_MG),
    .waddr (i_r[PT_AW-1:0]),
    .wdata (best),
    .raddr (pidx_r),
    .rdata (lbl_rdata)
  );

  // Shared divider for the means.
  logic             div_start;
  logic             div_busy;
  logic             div_done;
  logic [SUM_W-1:0] div_q;
  logic [SUM_W-1:0] sel_sum;
  logic [CNT_W-1:0] sel_cnt;

  // Cluster lanes.
  lane_ctl_t         lane_ctl  [NUM_CLUSTERS];
  logic [DIST_W-1:0] lane_dist [NUM_CLUSTERS];
  point_t            lane_cent [NUM_CLUSTERS];
  sums_t             lane_sum  [NUM_CLUSTERS];
  logic [CNT_W-1:0]  lane_cnt  [NUM_CLUSTERS];

  always_comb begin
    for (int c = 0; c < NUM_CLUSTERS; c++) begin
      lane_ctl[c].clear  = (state_r == ST_RUN) || (state_r == ST_PASS);
      lane_ctl[c].acc    = (state_r == ST_A_MG) && (best == CL_W'(c));
      lane_ctl[c].seed   = (state_r == ST_SEED_WR) && (cidx_r == CL_W'(c));
      lane_ctl[c].wr     = (state_r == ST_U_WAIT) && div_done && (c_r == 4'(c));
      lane_ctl[c].wr_dim = j_r;
      lane_ctl[c].wr_val = div_q[COORD_W-1:0];
      lane_ctl[c].dims   = dims_use;
    end
  end

  for (genvar g = 0; g < NUM_CLUSTERS; g++) begin : g_lane
    kmlc_lane u_lane (
      .clk     (clk),
      .ctl     (lane_ctl[g]),
      .pt      (pt_r),
      .sq_dist (lane_dist[g]),
      .cent    (lane_cent[g]),
      .sums    (lane_sum[g]),
      .count   (lane_cnt[g])
    );
  end

  // Merging stage: the nearest lane in use wins, the lower index on a tie.
  always_comb begin
    logic [DIST_W-1:0] best_d;
    best   = '0;
    best_d = lane_dist[0];
    for (int c = 1; c < NUM_CLUSTERS; c++) begin
      if ((4'(c) < k_use) && (lane_dist[c] < best_d)) begin
        best   = CL_W'(c);
        best_d = lane_dist[c];
      end
    end
  end

  // Update step: the mean of one coordinate of one cluster at a time.
  logic signed [COORD_W:0] mv_diff;
  logic [COORD_W:0]        mv_abs;
  logic                    moved_now;
  logic [COORD_W-1:0]      old_coord;

  assign sel_sum   = lane_sum[c_r[CL_W-1:0]][j_r];
  assign sel_cnt   = lane_cnt[c_r[CL_W-1:0]];
  assign old_coord = lane_cent[c_r[CL_W-1:0]][j_r];
  assign div_start = (state_r == ST_U_SEL) && (c_r < k_use) && (sel_cnt != '0);
  assign mv_diff   = $signed({div_q[COORD_W-1], div_q[COORD_W-1:0]})
                   - $signed({old_coord[COORD_W-1], old_coord});
  assign mv_abs    = mv_diff[COORD_W] ? (~mv_diff + 1'b1) : mv_diff;
  assign moved_now = mv_abs > {1'b0, tol_r};

  kmlc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sel_sum),
    .divisor  (sel_cnt),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  // Output register.
  logic             out_tvalid_r;
  logic             out_kind_r;
  logic [CL_W-1:0]  out_id_r;
  point_t           out_cent_r;
  logic [CNT_W-1:0] out_cnt_r;
  logic [7:0]       out_pass_r;
  logic             out_conv_r;
  logic             out_last_r;
  logic             out_free;

  assign out_free = !out_tvalid_r || out_tready;

  // Sequencer with its registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            pidx_r <= in_pidx;
            cidx_r <= in_cidx;
            unique case (in_act)
              ACT_SEED:  state_r <= ST_SEED_RD;
              ACT_RUN:   state_r <= ST_RUN;
              ACT_LABEL: state_r <= ST_LBL_RD;
              default:   state_r <= ST_IDLE;
            endcase
          end
        end
        ST_SEED_RD: state_r <= ST_SEED_LAT;
        ST_SEED_LAT: begin
          pt_r    <= pt_rdata;
          state_r <= ST_SEED_WR;
        end
        ST_SEED_WR: state_r <= ST_IDLE;
        ST_LBL_RD:  state_r <= ST_LBL_OUT;
        ST_LBL_OUT: begin
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            out_kind_r   <= 1'b0;
            out_id_r     <= lbl_rdata;
            out_cent_r   <= '0;
            out_cnt_r    <= '0;
            out_pass_r   <= '0;
            out_conv_r   <= 1'b0;
            out_last_r   <= 1'b1;
            state_r      <= ST_IDLE;
          end
        end
        ST_RUN: begin
          pass_r  <= '0;
          conv_r  <= 1'b0;
          c_r     <= '0;
          state_r <= (pass_lim_r == 8'd0) ? ST_REP : ST_PASS;
        end
        ST_PASS: begin
          pass_r  <= pass_r + 1'b1;
          moved_r <= 1'b0;
          i_r     <= '0;
          state_r <= ST_A_RD;
        end
        ST_A_RD: state_r <= ST_A_LAT;
        ST_A_LAT: begin
          pt_r    <= pt_rdata;
          state_r <= ST_A_SQ;
        end
        ST_A_SQ: state_r <= ST_A_DS;
        ST_A_DS: state_r <= ST_A_MG;
        ST_A_MG: begin
          i_r <= i_r + 1'b1;
          if ((i_r + 1'b1) == n_use) begin
            c_r     <= '0;
            j_r     <= '0;
            state_r <= ST_U_SEL;
          end else begin
            state_r <= ST_A_RD;
          end
        end
        ST_U_SEL: begin
          if (c_r >= k_use) begin
            state_r <= ST_P_END;
          end else if (sel_cnt == '0) begin
            // An empty cluster keeps its centroid.
            c_r <= c_r + 1'b1;
            j_r <= '0;
          end else begin
            state_r <= ST_U_WAIT;
          end
        end
        ST_U_WAIT: begin
          if (div_done) begin
            if (moved_now) begin
              moved_r <= 1'b1;
            end
            if (j_r == DIM_W'(NUM_DIMS - 1)) begin
              j_r <= '0;
              c_r <= c_r + 1'b1;
            end else begin
              j_r <= j_r + 1'b1;
            end
            state_r <= ST_U_SEL;
          end
        end
        ST_P_END: begin
          c_r <= '0;
          if (!moved_r) begin
            conv_r  <= 1'b1;
            state_r <= ST_REP;
          end else if (pass_r == pass_lim_r) begin
            state_r <= ST_REP;
          end else begin
            state_r <= ST_PASS;
          end
        end
        ST_REP: begin
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            out_kind_r   <= 1'b1;
            out_id_r     <= c_r[CL_W-1:0];
            out_cent_r   <= lane_cent[c_r[CL_W-1:0]];
            out_cnt_r    <= lane_cnt[c_r[CL_W-1:0]];
            out_pass_r   <= pass_r;
            out_conv_r   <= conv_r;
            out_last_r   <= (c_r == (k_use - 1'b1));
            if (c_r == (k_use - 1'b1)) begin
              state_r <= ST_IDLE;
            end else begin
              c_r <= c_r + 1'b1;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {1'b0, out_conv_r, out_pass_r, out_cnt_r, out_cent_r, out_id_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  // The divider is never restarted while a division is still running.
  `KMLC_ASSERT_SAME(a_div_idle_on_start, div_start, !div_busy)
  // The merging stage only ever sees a point that takes part in the run.
  `KMLC_ASSERT_SAME(a_merge_in_range, state_r == ST_A_MG, i_r < n_use)
  // A centroid record never reports more passes than the limit allows.
  `KMLC_ASSERT_SAME(a_pass_bound, out_tvalid_r && out_kind_r, out_pass_r <= pass_lim_r)

endmodule

// ----- tb/kmeans_lloyd_cluster_core_test.sv -----
// Self-checking testbench for kmeans_lloyd_cluster_core: stream beats in and
// out, APB register writes, and a behavioral k-means predictor with scoreboard.
// Depends on kmlc_pkg and the core RTL only.
`timescale 1ns / 1ps

module kmeans_lloyd_cluster_core_test;
  import kmlc_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000000;
  localparam int DRAIN_CYCLES   = 12;
  localparam int PRELOAD_POINTS = 32;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [87:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  kmeans_lloyd_cluster_core dut (.*);

  always #2 clk = ~clk;

  // One output beat as the predictor sees it.
  typedef struct {
    bit              kind;
    bit [2:0]        cluster_id;
    bit [15:0]       center[4];
    bit [10:0]       members;
    bit [7:0]        passes;
    bit              converged;
    bit              last;
  } record_t;

  record_t pending_records[$];

  // Predictor state: shadow registers and stores.
  bit [3:0]  sh_clusters = 4'd2;
  bit [7:0]  sh_pass_limit = 8'd100;
  bit [10:0] sh_points = 11'd1;
  bit [2:0]  sh_dims = 3'd4;
  bit [15:0] sh_tol = 16'd0;

  logic signed [15:0] point_mem[NUM_POINTS][NUM_DIMS];
  longint             centroid_mem[NUM_CLUSTERS][NUM_DIMS];
  bit [2:0]           label_mem[NUM_POINTS];
  bit                 label_known[NUM_POINTS];

  int mismatches = 0;
  int items_sent = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;
  int quiet_cycles = 0;

  // Recompute the clustering exactly as the block should: assign by squared
  // distance with lowest index winning ties, then truncating means.
  task automatic predict_run();
    int      k, n, nd, passes;
    bit      conv, moved;
    longint  sums[NUM_CLUSTERS][NUM_DIMS];
    longint  members[NUM_CLUSTERS];
    longint  diff, dsq, best_d, mean;
    int      best;
    record_t rec;
    k  = (sh_clusters == 0) ? 1 : (sh_clusters > NUM_CLUSTERS) ? NUM_CLUSTERS : sh_clusters;
    n  = (sh_points == 0) ? 1 : (sh_points > NUM_POINTS) ? NUM_POINTS : sh_points;
    nd = (sh_dims == 0) ? 1 : (sh_dims > NUM_DIMS) ? NUM_DIMS : sh_dims;
    passes = 0;
    conv = 0;
    foreach (members[c]) members[c] = 0;
    while (passes < sh_pass_limit) begin
      passes++;
      moved = 0;
      foreach (sums[c, j]) sums[c][j] = 0;
      foreach (members[c]) members[c] = 0;
      for (int i = 0; i < n; i++) begin
        best = 0;
        best_d = 0;
        for (int c = 0; c < k; c++) begin
          dsq = 0;
          for (int j = 0; j < nd; j++) begin
            diff = longint'(point_mem[i][j]) - centroid_mem[c][j];
            dsq += diff * diff;
          end
          if (c == 0 || dsq < best_d) begin
            best_d = dsq;
            best = c;
          end
        end
        label_mem[i] = best;
        label_known[i] = 1;
        members[best]++;
        // Unused dimensions still feed the means.
        for (int j = 0; j < NUM_DIMS; j++) sums[best][j] += point_mem[i][j];
      end
      for (int c = 0; c < k; c++) begin
        if (members[c] != 0) begin
          for (int j = 0; j < NUM_DIMS; j++) begin
            mean = sums[c][j] / members[c];
            if ((mean > centroid_mem[c][j] ? mean - centroid_mem[c][j]
                                           : centroid_mem[c][j] - mean) > sh_tol)
              moved = 1;
            centroid_mem[c][j] = mean;
          end
        end
      end
      if (!moved) begin
        conv = 1;
        break;
      end
    end
    for (int c = 0; c < k; c++) begin
      rec.kind = 1;
      rec.cluster_id = c;
      for (int j = 0; j < NUM_DIMS; j++) rec.center[j] = centroid_mem[c][j];
      rec.members = members[c];
      rec.passes = passes;
      rec.converged = conv;
      rec.last = (c == k - 1);
      pending_records.insert(pending_records.size(), rec);
    end
  endtask

  // Update the predictor for one accepted input beat.
  task automatic predict_beat(action_t act, int pidx, int cidx, logic [15:0] crd[4]);
    record_t rec;
    case (act)
      ACT_LOAD: begin
        for (int j = 0; j < NUM_DIMS; j++) point_mem[pidx][j] = crd[j];
      end
      ACT_SEED: begin
        for (int j = 0; j < NUM_DIMS; j++) centroid_mem[cidx][j] = point_mem[pidx][j];
      end
      ACT_LABEL: begin
        rec = '{default: 0};
        rec.cluster_id = label_mem[pidx];
        rec.last = 1;
        pending_records.insert(pending_records.size(), rec);
      end
      default: predict_run();
    endcase
  endtask

  // Offer one beat; the sender may idle first. tvalid stays high between
  // back-to-back beats so it never gets two assignments in one step.
  task automatic send_item(action_t act, int pidx, int cidx = 0,
                           logic [15:0] a = 0, logic [15:0] b = 0,
                           logic [15:0] c = 0, logic [15:0] d = 0);
    logic [15:0] crd[4];
    crd = '{a, b, c, d};
    if ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {3'b000, d, c, b, a, 3'(cidx), 10'(pidx)};
    do @(posedge clk); while (!in_tready);
    predict_beat(act, pidx, cidx, crd);
    items_sent++;
  endtask

  // Drop tvalid, then wait until the block has drained every expected beat
  // and had time to finish any load or seed that gives no result.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_records.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write: setup beat, then access beat; pready is always high. The
  // caller ends the transfer so that writes can follow back to back.
  task automatic write_reg(logic [2:0] idx, int unsigned value);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_CLUSTER_COUNT: sh_clusters   = value;
      REG_PASS_LIMIT:    sh_pass_limit = value;
      REG_POINT_COUNT:   sh_points     = value;
      REG_DIMS_IN_USE:   sh_dims       = value;
      REG_MOVE_TOL:      sh_tol        = value;
      default: ;
    endcase
  endtask

  task automatic write_all(int unsigned k, int unsigned lim, int unsigned n,
                           int unsigned nd, int unsigned tol);
    write_reg(REG_CLUSTER_COUNT, k);
    write_reg(REG_PASS_LIMIT, lim);
    write_reg(REG_POINT_COUNT, n);
    write_reg(REG_DIMS_IN_USE, nd);
    write_reg(REG_MOVE_TOL, tol);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return $urandom;
      default: return 16'($signed($urandom_range(800)) - 400);
    endcase
  endfunction

  // The first points are written up front so later runs and seeds never
  // touch an unwritten entry; all eight centroid slots get seeded too.
  task automatic test_preload();
    for (int i = 0; i < PRELOAD_POINTS; i++)
      send_item(ACT_LOAD, i, 0, rand_coord(), rand_coord(), rand_coord(), rand_coord());
    for (int c = 0; c < NUM_CLUSTERS; c++)
      send_item(ACT_SEED, $urandom_range(PRELOAD_POINTS - 1), c);
    // Run with the register values left by reset.
    send_item(ACT_RUN, 0);
    send_item(ACT_LABEL, 0);
    wait_idle();
  endtask

  task automatic test_directed();
    send_item(ACT_LOAD, 0, 0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_item(ACT_LOAD, 1, 0, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_item(ACT_LOAD, 1023, 0, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000);
    send_item(ACT_SEED, 0, 0);
    send_item(ACT_SEED, 1, 7);
    send_item(ACT_SEED, 1023, 6);
    wait_idle();
    // Zero pass limit: records carry the seeded centroids, no members.
    write_all(8, 0, 4, 4, 0);
    send_item(ACT_RUN, 0);
    wait_idle();
    // Cluster and dims counts below and above range saturate; long limit.
    write_all(0, 255, PRELOAD_POINTS, 7, 0);
    send_item(ACT_RUN, 0);
    send_item(ACT_LABEL, 5);
    wait_idle();
    // Point count and dims of zero saturate to one; loose tolerance.
    write_all(15, 2, 0, 0, 65535);
    send_item(ACT_RUN, 0);
    send_item(ACT_LABEL, 0);
    wait_idle();
    // Two slots seeded from one point tie on distance: lower index wins.
    // Point 20 keeps the label from an earlier run.
    send_item(ACT_SEED, 2, 3);
    send_item(ACT_SEED, 2, 4);
    wait_idle();
    write_all(8, 5, 10, 2, 3);
    send_item(ACT_RUN, 0);
    send_item(ACT_LABEL, 20);
    send_item(ACT_LABEL, 3);
    wait_idle();
  endtask

  // Random well-formed rounds: reconfigure, reload a few points, reseed,
  // run, then read back some labels.
  task automatic test_random(int target);
    int start, n;
    start = items_sent;
    while (items_sent - start < target) begin
      wait_idle();
      write_all($urandom_range(15), $urandom_range(1, 12),
                ($urandom_range(9) == 0) ? 0 : $urandom_range(2, PRELOAD_POINTS),
                $urandom_range(7),
                ($urandom_range(3) == 0) ? $urandom : $urandom_range(3));
      if ($urandom_range(4) != 0) begin
        repeat ($urandom_range(4))
          send_item(ACT_LOAD, $urandom_range(PRELOAD_POINTS - 1), 0,
                    rand_coord(), rand_coord(), rand_coord(), rand_coord());
        repeat ($urandom_range(1, 8))
          send_item(ACT_SEED, $urandom_range(PRELOAD_POINTS - 1), $urandom_range(7));
      end
      send_item(ACT_RUN, 0);
      repeat ($urandom_range(1, 4)) begin
        n = $urandom_range(PRELOAD_POINTS - 1);
        if (!label_known[n]) n = 0;
        send_item(ACT_LABEL, n);
      end
    end
    wait_idle();
  endtask

  // Hold the receiver off so the output register fills and input stalls.
  task automatic test_backpressure();
    write_all(8, 1, 4, 4, 0);
    hold_cycles = 3000;
    send_item(ACT_RUN, 0);
    repeat (6) send_item(ACT_LABEL, $urandom_range(1));
    wait_idle();
  endtask

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready  <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Scoreboard: each output beat against the oldest expected record.
  always @(posedge clk) begin
    record_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind = out_tuser[0];
      got.cluster_id = out_tdata[2:0];
      got.center[0] = out_tdata[18:3];
      got.center[1] = out_tdata[34:19];
      got.center[2] = out_tdata[50:35];
      got.center[3] = out_tdata[66:51];
      got.members = out_tdata[77:67];
      got.passes = out_tdata[85:78];
      got.converged = out_tdata[86];
      got.last = out_tlast;
      if (pending_records.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output beat: %p", got);
      end else begin
        want = pending_records.pop_front();
        if (got.kind != want.kind || got.cluster_id != want.cluster_id ||
            got.center != want.center || got.members != want.members ||
            got.passes != want.passes || got.converged != want.converged ||
            got.last != want.last) begin
          mismatches++;
          if (mismatches <= 10) $display("output mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  // Watchdog on cycles with no beat accepted on either stream.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    foreach (label_known[i]) label_known[i] = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_preload();
    test_directed();
    test_random(8);
    gap_pct = 55;
    test_random(8);
    gap_pct = 0;
    stall_pct = 55;
    test_random(8);
    gap_pct = 36;
    stall_pct = 36;
    test_random(8);
    test_backpressure();
    repeat (50) @(posedge clk);
    if (mismatches == 0 && pending_records.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
